// ===== rtl/core/cwg_pkg.sv =====
package cwg_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int PULSE_SAMPLES    = 3;

   // quarter wave resolution of the quantised angle
   localparam int QTR_BITS = $clog2(SINE_TABLE_DEPTH) - 2;
   localparam int QTR      = 1 << QTR_BITS;

   // divider numerator width: index * multiple * 256
   localparam int DIV_W   = 40;
   localparam int DIV_CNT = $clog2(DIV_W + 1);

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_TYPE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLE  = 3'd5;

   localparam logic [3:0] WAVE_SINE   = 4'd0;
   localparam logic [3:0] WAVE_COS    = 4'd1;
   localparam logic [3:0] WAVE_HANN   = 4'd2;
   localparam logic [3:0] WAVE_TRI    = 4'd3;
   localparam logic [3:0] WAVE_SAW    = 4'd4;
   localparam logic [3:0] WAVE_RSAW   = 4'd5;
   localparam logic [3:0] WAVE_RSINE  = 4'd6;
   localparam logic [3:0] WAVE_PULSE  = 4'd7;
   localparam logic [3:0] WAVE_SQUARE = 4'd8;
   localparam logic [3:0] WAVE_FLAT   = 4'd9;

   typedef struct packed {
      logic [3:0]         wave_type;
      logic [15:0]        cycle_len;
      logic signed [15:0] amplitude;
      logic signed [15:0] offset_level;
      logic [15:0]        phase_turns;
      logic [15:0]        period_multiple;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic div_step;
      logic shape;
      logic mul;
      logic add;
      logic scale;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef logic [31:0] sin_tab_type [QTR];

   // sine of m quarter-wave steps, Q30, by the integer series
   function automatic logic [31:0] sin_q30(input int m);
      longint unsigned r, x, x2, t;
      r  = longint'(m) << (30 - QTR_BITS);
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      t  = (x * t) >> 30;
      return t[31:0];
   endfunction

   // entry k holds the sine of k+1 steps
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type tab;
      for (int k = 0; k < QTR; k++) begin
         tab[k] = sin_q30(k + 1);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

endpackage

// ===== rtl/core/cycle_waveform_generator_core.sv =====
// looped single-cycle oscillator: each word taken on req gives one word on rsp holding
// the next sample of the selected waveform (sine, cosine, hann, triangle, saw, reversed
// saw, short triangle pulse, half square, flat) and a flag on the last sample of the
// cycle; req_restart puts the index back to zero first. an accepted word goes through
// index setup, the bit-serial divider (angle = index * multiple * 256 / cycle length,
// or pulse length for the pulse; saw level = index * 32766 / (cycle length - 1),
// index counted down for the reversed saw), shaping, gain, offset, scaling and the
// output load. the finished word waits in an output register so the next word is
// taken as soon as the datapath is free; while that register is full and the receiver
// stalls the datapath holds in its last step. csr writes belong in idle periods only
module cycle_waveform_generator_core
   import cwg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [15:0]   rsp_sample,
   output logic                 rsp_cycle_end,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // register file, indices above the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_type       <= WAVE_SINE;
         cfg_ff.cycle_len       <= 16'd256;
         cfg_ff.amplitude       <= 16'sd4096;
         cfg_ff.offset_level    <= 16'sd0;
         cfg_ff.phase_turns     <= 16'd0;
         cfg_ff.period_multiple <= 16'd256;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WAVE_TYPE: cfg_ff.wave_type       <= csr_wdata[3:0];
            CSR_CYCLE_LEN: cfg_ff.cycle_len       <= csr_wdata;
            CSR_AMPLITUDE: cfg_ff.amplitude       <= $signed(csr_wdata);
            CSR_OFFSET:    cfg_ff.offset_level    <= $signed(csr_wdata);
            CSR_PHASE:     cfg_ff.phase_turns     <= csr_wdata;
            CSR_MULTIPLE:  cfg_ff.period_multiple <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer
   cwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // index, divider, shape and scaling
   cwg_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .status        (status),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_cycle_end (rsp_cycle_end)
   );

endmodule

// ===== rtl/core/cwg_ctrl.sv =====
module cwg_ctrl
   import cwg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_DIV_START, ST_DIV_RUN, ST_SHAPE,
      ST_MUL, ST_ADD, ST_SCALE, ST_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT-1:0]   cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT'(DIV_W - 1)) begin
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            cmd.shape = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/cwg_dp.sv =====
module cwg_dp
   import cwg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_cycle_end
);

   localparam logic signed [33:0] Q30_ONE = 34'sd1 << 30;
   localparam logic signed [66:0] CLAMP_LIM = 67'sd32767 <<< 42;
   localparam logic signed [66:0] ROUND_ADJ = (67'sd1 <<< 42) - 67'sd1;

   logic [15:0]        len;
   logic [15:0]        idx_ff, idx_in;
   logic [15:0]        i_ff, i_in;
   logic               end_ff, end_in;
   logic [31:0]        mprod_ff;
   logic [15:0]        mul_a, mul_b;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        dvs_ff, dvs_in;
   logic [16:0]        trial;
   logic [17:0]        diff;
   logic               is_saw;

   logic [15:0]          theta;
   logic [1:0]           quad;
   logic [QTR_BITS-1:0]  mfrac;
   logic [QTR_BITS:0]    mm;
   logic [QTR_BITS:0]    mm_m1;
   logic signed [33:0]   trig_t, trig_s, hann_h, hann_w, tri_w;
   logic signed [17:0]   tri_d;
   logic [17:0]          tri_abs;

   logic signed [33:0]   w_ff, w_in;
   logic                 use_off_ff, use_off_in;
   logic                 use_quo_ff, use_quo_in;
   logic                 quo_zero_ff, quo_zero_in;
   logic signed [49:0]   prod_ff;
   logic signed [50:0]   n_ff;
   logic signed [66:0]   m_ff;
   logic signed [66:0]   m_adj;
   logic signed [15:0]   fin_s;
   logic signed [15:0]   smp_in;
   logic                 valid_ff;

   assign len    = (cfg.cycle_len == 16'd0) ? 16'd1 : cfg.cycle_len;
   assign is_saw = (cfg.wave_type == WAVE_SAW) || (cfg.wave_type == WAVE_RSAW);

   // index bookkeeping at accept
   always_comb begin
      i_in   = (req_restart || idx_ff >= len) ? 16'd0 : idx_ff;
      end_in = (i_in == len - 16'd1);
      idx_in = ({1'b0, i_in} + 17'd1 >= {1'b0, len}) ? 16'd0 : i_in + 16'd1;
   end

   // shared multiplier for angle numerator or saw numerator
   assign mul_a = (cfg.wave_type == WAVE_RSAW) ? (len - 16'd1 - i_ff) : i_ff;
   assign mul_b = is_saw ? 16'd32766 : cfg.period_multiple;

   // restoring divider, one quotient bit a cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      diff   = {1'b0, trial} - {2'b00, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         if (is_saw) begin
            quo_in = {{(DIV_W-32){1'b0}}, mprod_ff};
            dvs_in = len - 16'd1;
         end else begin
            quo_in = {mprod_ff, {(DIV_W-32){1'b0}}};
            dvs_in = (cfg.wave_type == WAVE_PULSE) ? 16'(PULSE_SAMPLES) : len;
         end
      end else if (cmd.div_step) begin
         if (!diff[17]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   // waveform shape in q30
   always_comb begin
      theta = quo_ff[15:0] + cfg.phase_turns;
      quad  = theta[15:14] + {1'b0, (cfg.wave_type == WAVE_COS) ||
                                    (cfg.wave_type == WAVE_HANN)};
      mfrac = theta[13 -: QTR_BITS];
      mm    = quad[0] ? ((QTR_BITS+1)'(QTR) - {1'b0, mfrac}) : {1'b0, mfrac};
      mm_m1 = mm - 1'b1;
      trig_t = (mm == '0) ? 34'sd0 : $signed({2'b00, SIN_TAB[mm_m1[QTR_BITS-1:0]]});
      trig_s = quad[1] ? -trig_t : trig_t;
      hann_h = Q30_ONE - trig_s;
      // halve, truncating toward zero
      hann_w = (hann_h + ((hann_h < 0) ? 34'sd1 : 34'sd0)) >>> 1;
      tri_d   = $signed({1'b0, theta, 1'b0}) - 18'sd65536;
      tri_abs = tri_d[17] ? 18'(-tri_d) : 18'(tri_d);
      tri_w   = (34'sd65536 - $signed({16'd0, tri_abs})) <<< 14;

      w_in        = '0;
      use_off_in  = 1'b1;
      use_quo_in  = 1'b0;
      quo_zero_in = (len == 16'd1);
      case (cfg.wave_type)
         WAVE_COS:  w_in = trig_s;
         WAVE_HANN: w_in = hann_w;
         WAVE_TRI:  w_in = tri_w;
         WAVE_SAW, WAVE_RSAW: begin
            use_quo_in = 1'b1;
         end
         WAVE_PULSE: begin
            if (i_ff < 16'(PULSE_SAMPLES)) begin
               w_in = tri_w;
            end else begin
               use_off_in = 1'b0;
            end
         end
         WAVE_SQUARE: begin
            use_off_in = 1'b0;
            if (i_ff < (len >> 1)) begin
               w_in = Q30_ONE;
            end
         end
         WAVE_FLAT: begin
            use_off_in = 1'b0;
            w_in       = Q30_ONE;
         end
         default:   w_in = trig_s;
      endcase
   end

   // clamp and truncate toward zero
   always_comb begin
      m_adj = m_ff + ((m_ff < 0) ? ROUND_ADJ : 67'sd0);
      if (m_ff > CLAMP_LIM) begin
         fin_s = 16'sd32766;
      end else if (m_ff < -CLAMP_LIM) begin
         fin_s = -16'sd32766;
      end else begin
         fin_s = m_adj[57:42];
      end
      if (use_quo_ff) begin
         smp_in = quo_zero_ff ? 16'sd0 : $signed(quo_ff[15:0]);
      end else begin
         smp_in = fin_s;
      end
   end

   assign status.out_free = !valid_ff || !rsp_stall;
   assign rsp_valid       = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= idx_in;
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         i_ff   <= i_in;
         end_ff <= end_in;
      end
      if (cmd.prep) begin
         mprod_ff <= mul_a * mul_b;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (cmd.shape) begin
         w_ff        <= w_in;
         use_off_ff  <= use_off_in;
         use_quo_ff  <= use_quo_in;
         quo_zero_ff <= quo_zero_in;
      end
      if (cmd.mul) begin
         prod_ff <= 50'(w_ff) * 50'(cfg.amplitude);
      end
      if (cmd.add) begin
         n_ff <= 51'(prod_ff) +
                 (use_off_ff ? (51'(cfg.offset_level) <<< 30) : 51'sd0);
      end
      if (cmd.scale) begin
         // times 32766 as 32768 minus 2
         m_ff <= (67'(n_ff) <<< 15) - (67'(n_ff) <<< 1);
      end
      if (cmd.out_load) begin
         rsp_sample    <= smp_in;
         rsp_cycle_end <= end_ff;
      end
   end

endmodule

// ===== sim/cwg_checker.sv =====
`timescale 1ns / 100ps

module cwg_checker
   import cwg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_restart,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [15:0]   rsp_sample,
   input  logic                 rsp_cycle_end,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output int                   fail_count,
   output int                   words_due,
   output int                   words_seen
);

   typedef struct {
      logic signed [15:0] sample;
      logic               cycle_end;
   } sample_word_type;

   sample_word_type    samples_due[$];

   logic [3:0]         wave_code;
   logic [15:0]        cyc_len;
   logic signed [15:0] gain;
   logic signed [15:0] dc_level;
   logic [15:0]        start_phase;
   logic [15:0]        multiple;
   logic [15:0]        index_now;

   // sin of a Q32 turn, Q30 result
   function automatic longint turn_sine(longint unsigned u);
      longint unsigned dens[5];
      longint unsigned quad, r, x, x2, t;
      dens = '{110, 72, 42, 20, 6};
      quad = (u >> 30) & 3;
      r = u & 64'h3FFF_FFFF;
      if (quad[0])
         r = 64'h4000_0000 - r;
      x = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int k = 0; k < 5; k++)
         t = (64'd1 << 30) - ((x2 * t) >> 30) / dens[k];
      t = (x * t) >> 30;
      return quad >= 2 ? -longint'(t) : longint'(t);
   endfunction

   function automatic longint unsigned quant_turn(longint unsigned theta);
      longint unsigned step;
      step = ((theta & 16'hFFFF) * SINE_TABLE_DEPTH) >> 16;
      return ((step << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
   endfunction

   function automatic longint tri_shape(longint unsigned theta);
      longint d;
      d = longint'((theta & 16'hFFFF) * 2) - 65536;
      if (d < 0)
         d = -d;
      return (65536 - d) * (64'sd1 << 14);
   endfunction

   function automatic logic signed [15:0] scale_out(longint w, bit with_dc);
      longint n;
      longint lim;
      lim = 64'sd32767 <<< 42;
      n = w * longint'(gain);
      if (with_dc)
         n += longint'(dc_level) * (64'sd1 <<< 30);
      n *= 32766;
      if (n > lim)
         return 16'sd32766;
      if (n < -lim)
         return -16'sd32766;
      return 16'(n / (64'sd1 <<< 42));
   endfunction

   // next sample and end-of-cycle flag; advances the index
   function automatic sample_word_type next_sample(logic restart);
      sample_word_type w;
      longint unsigned len, i, theta, th;
      longint s;
      len = (cyc_len == 0) ? 1 : cyc_len;
      if (restart || index_now >= len)
         index_now = 0;
      i = index_now;
      theta = ((i * multiple * 256) / len + start_phase) & 16'hFFFF;
      s = 0;
      case (wave_code)
         WAVE_COS:
            s = scale_out(turn_sine((quant_turn(theta) + 64'h4000_0000) & 64'hFFFF_FFFF), 1);
         WAVE_HANN:
            s = scale_out(((64'sd1 <<< 30)
                - turn_sine((quant_turn(theta) + 64'h4000_0000) & 64'hFFFF_FFFF)) / 2, 1);
         WAVE_TRI: s = scale_out(tri_shape(theta), 1);
         WAVE_SAW: s = len > 1 ? longint'((i * 32766) / (len - 1)) : 0;
         WAVE_RSAW: s = len > 1 ? longint'(((len - 1 - i) * 32766) / (len - 1)) : 0;
         WAVE_PULSE: begin
            if (i < PULSE_SAMPLES) begin
               th = ((i * multiple * 256) / PULSE_SAMPLES + start_phase) & 16'hFFFF;
               s = scale_out(tri_shape(th), 1);
            end
         end
         WAVE_SQUARE: if (i < len / 2) s = scale_out(64'sd1 <<< 30, 0);
         WAVE_FLAT: s = scale_out(64'sd1 <<< 30, 0);
         default: s = scale_out(turn_sine(quant_turn(theta)), 1);
      endcase
      w.sample = 16'(s);
      w.cycle_end = (i == len - 1);
      index_now = (i + 1 >= len) ? 16'd0 : 16'(i + 1);
      return w;
   endfunction

   assign words_due = samples_due.size();

   always @(posedge clock) begin
      sample_word_type got, want;
      int errs;
      if (reset) begin
         wave_code <= WAVE_SINE;
         cyc_len <= 16'd256;
         gain <= 16'sd4096;
         dc_level <= 16'sd0;
         start_phase <= 16'd0;
         multiple <= 16'd256;
         index_now = 16'd0;
         samples_due.delete();
         fail_count <= 0;
         words_seen <= 0;
      end else begin
         errs = 0;
         if (csr_write) begin
            case (csr_index)
               CSR_WAVE_TYPE: wave_code <= csr_wdata[3:0];
               CSR_CYCLE_LEN: cyc_len <= csr_wdata;
               CSR_AMPLITUDE: gain <= csr_wdata;
               CSR_OFFSET:    dc_level <= csr_wdata;
               CSR_PHASE:     start_phase <= csr_wdata;
               CSR_MULTIPLE:  multiple <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            samples_due.push_back(next_sample(req_restart));
         if (rsp_valid && !rsp_stall) begin
            words_seen <= words_seen + 1;
            got.sample = rsp_sample;
            got.cycle_end = rsp_cycle_end;
            if (samples_due.size() == 0) begin
               $display("%0t: unexpected word, actual sample %0d cycle_end %0b",
                        $time, got.sample, got.cycle_end);
               errs++;
            end else begin
               want = samples_due.pop_front();
               if (got.sample !== want.sample) begin
                  $display("%0t: sample mismatch, expected %0d actual %0d",
                           $time, want.sample, got.sample);
                  errs++;
               end
               if (got.cycle_end !== want.cycle_end) begin
                  $display("%0t: cycle_end mismatch, expected %0b actual %0b",
                           $time, want.cycle_end, got.cycle_end);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import cwg_pkg::*;
();

   localparam int IDLE_WAIT = 120;
   localparam int HOLD_OFF  = 400;   // long receiver hold-off
   localparam int WATCHDOG  = 3000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_restart;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [15:0]   rsp_sample;
   logic                 rsp_cycle_end;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   int fail_count;
   int words_due;
   int words_seen;
   int words_sent;
   int settings_used;
   int quiet_cycles;
   int hold_asked;      // bumped by the stimulus to ask for a long hold-off
   int hold_done;

   cycle_waveform_generator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample), .rsp_cycle_end(rsp_cycle_end),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   cwg_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample), .rsp_cycle_end(rsp_cycle_end),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .words_due(words_due), .words_seen(words_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random bursts of stall and flow, plus the long hold-off on request
   initial begin
      int run_left;
      bit run_stall;
      rsp_stall = 1'b0;
      run_left = 0;
      run_stall = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
            run_left = 0;
         end
         if (run_left == 0) begin
            run_stall = 1'($urandom_range(0, 1));
            if (!run_stall)
               run_left = $urandom_range(1, 30);
            else if ($urandom_range(0, 9) == 0)
               run_left = $urandom_range(10, 40);
            else
               run_left = $urandom_range(1, 3);
         end
         run_left--;
         rsp_stall <= run_stall;
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog expired at %0t with %0d words outstanding", $time, words_due);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // block drained and datapath given time to go quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   // offer one word, hold until taken, then an optional gap
   task automatic send_word(logic restart, int gap);
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_restart <= 1'($urandom_range(0, 1));   // noise while idle
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // field value biased towards its extremes
   function automatic logic [15:0] pick_field();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'h1000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(100, 3000));
         default: return 16'($urandom_range(2, 24));
      endcase
   endfunction

   initial begin
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_WAVE_TYPE;
      csr_wdata = 16'd0;
      words_sent = 0;
      settings_used = 0;
      hold_asked = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, then every wave shape over a short cycle
      send_word(1'b0, 0);
      send_word(1'b1, 0);
      wait_idle();
      write_reg(CSR_CYCLE_LEN, 16'd4);
      write_reg(CSR_AMPLITUDE, 16'h7FFF);
      write_reg(CSR_OFFSET, 16'h8000);
      write_reg(CSR_PHASE, 16'hFFFF);
      write_reg(CSR_MULTIPLE, 16'hFFFF);
      for (int w = WAVE_SINE; w <= WAVE_FLAT; w++) begin
         write_reg(CSR_WAVE_TYPE, 16'(w));
         send_word(1'b1, 0);
         send_word(1'b0, 0);
         wait_idle();
         settings_used++;
      end
      // saw of length one, zero length, unused codes, ignored register indexes
      write_reg(CSR_CYCLE_LEN, 16'd1);
      write_reg(CSR_WAVE_TYPE, 16'(WAVE_RSAW));
      send_word(1'b0, 0);
      wait_idle();
      write_reg(CSR_CYCLE_LEN, 16'd0);
      write_reg(CSR_WAVE_TYPE, 16'd15);
      write_reg(3'd6, 16'hFFFF);
      write_reg(3'd7, 16'h1234);
      send_word(1'b0, 0);
      wait_idle();

      // random settings, each followed by a run of words
      for (int p = 0; p < 14; p++) begin
         write_reg(CSR_WAVE_TYPE, 16'($urandom_range(0, 15)));
         write_reg(CSR_CYCLE_LEN, pick_length());
         write_reg(CSR_AMPLITUDE, pick_field());
         write_reg(CSR_OFFSET, pick_field());
         write_reg(CSR_PHASE, pick_field());
         write_reg(CSR_MULTIPLE, pick_field());
         if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(6, 7)), 16'($urandom_range(0, 65535)));
         settings_used++;
         burst = $urandom_range(70, 100);
         for (int n = 0; n < burst; n++) begin
            if (p == 3 && n == 10)
               hold_asked++;   // receiver holds off while we keep offering
            if (n == burst / 2 && p % 4 == 1) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (words_due != 0) @(posedge clock);
            end
            // a stretch with no gaps on our side every few phases
            send_word($urandom_range(0, 19) == 0, (p % 5 == 2) ? 0 : pick_gap());
         end
         wait_idle();
      end

      repeat (IDLE_WAIT) @(posedge clock);
      $display("sent %0d words over %0d settings, %0d words checked",
               words_sent, settings_used, words_seen);
      $display("covered every wave code, extreme gain and dc, and stalls on both channels");
      if (fail_count == 0 && words_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
